// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/hkmc_pkg.sv =====
`timescale 1ns / 1ps

package hkmc_pkg;

    localparam int ANGLE_WIDTH   = 24;
    localparam int FRACTION_BITS = 16;
    localparam int COUNT_WIDTH   = 16;
    localparam int STEP_WIDTH    = 19;
    localparam int MODE_WIDTH    = 3;

    // widest signed compare: angle differences, step, three times one
    localparam int WIDE_A     = ANGLE_WIDTH + 2;
    localparam int WIDE_B     = (STEP_WIDTH + 1 > FRACTION_BITS + 4) ? STEP_WIDTH + 1
                                                                     : FRACTION_BITS + 4;
    localparam int CALC_WIDTH = (WIDE_A > WIDE_B) ? WIDE_A : WIDE_B;

    localparam int DATA_WIDTH = 32;
    localparam int REG_COUNT  = 5;
    localparam int ADDR_WIDTH = $clog2(4 * (REG_COUNT - 1) + 1);
    localparam int IDX_WIDTH  = ADDR_WIDTH - 2;

    localparam int IN_DATA_WIDTH  = ((2 * ANGLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELDS     = 2 * ANGLE_WIDTH + 4 + COUNT_WIDTH;
    localparam int OUT_DATA_WIDTH = ((OUT_FIELDS + 7) / 8) * 8;

    typedef logic [ANGLE_WIDTH-1:0]       t_angle;
    typedef logic [COUNT_WIDTH-1:0]       t_count;
    typedef logic [STEP_WIDTH-1:0]        t_step;
    typedef logic signed [CALC_WIDTH-1:0] t_calc;

    // fixed point constants
    localparam longint unsigned PI_Q32   = 64'd13493037705;
    localparam int              PI_SHIFT = 32 - FRACTION_BITS;
    localparam longint unsigned ONE_VAL  = 64'd1 << FRACTION_BITS;

    localparam longint unsigned STEP_RST_VAL =
        (PI_Q32 + (64'd3 << PI_SHIFT)) / (64'd6 << PI_SHIFT);
    localparam longint unsigned HIGH_RST_VAL  = ((64'd51 << FRACTION_BITS) + 64'd5) / 64'd10;
    localparam longint unsigned LOW_RST_VAL   = ((64'd33 << FRACTION_BITS) + 64'd5) / 64'd10;
    localparam longint unsigned START_ANG_VAL = ((64'd42 << FRACTION_BITS) + 64'd5) / 64'd10;
    localparam longint unsigned SPIN_VEL_VAL  = 64'd15 * ONE_VAL;

    localparam t_step  DETENT_STEP_RST = STEP_WIDTH'(STEP_RST_VAL);
    localparam t_angle LIMIT_HIGH_RST  = ANGLE_WIDTH'(HIGH_RST_VAL);
    localparam t_angle LIMIT_LOW_RST   = ANGLE_WIDTH'(LOW_RST_VAL);
    localparam t_angle START_ANGLE     = ANGLE_WIDTH'(START_ANG_VAL);
    localparam t_angle SPIN_VELOCITY   = ANGLE_WIDTH'(SPIN_VEL_VAL);
    localparam t_calc  ONE_Q           = CALC_WIDTH'(ONE_VAL);
    localparam t_calc  THREE_Q         = CALC_WIDTH'(3 * ONE_VAL);

    typedef enum logic [MODE_WIDTH-1:0] {
        KNOB_OFF     = 3'd0,
        KNOB_INERTIA = 3'd1,
        KNOB_DETENT  = 3'd2,
        KNOB_SPRING  = 3'd3,
        KNOB_DAMPER  = 3'd4,
        KNOB_SPIN    = 3'd5
    } t_mode;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    localparam logic [IDX_WIDTH-1:0] REG_KNOB_MODE   = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_ZERO_OFFSET = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_DETENT_STEP = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_LIMIT_HIGH  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_LIMIT_LOW   = 3'd4;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] knob_mode;
        t_angle                zero_offset;
        t_step                 detent_step;
        t_angle                limit_high;
        t_angle                limit_low;
    } t_cfg;

    typedef struct packed {
        t_angle last_angle;
        t_angle last_velocity;
        t_angle angle_goal;
        t_angle velocity_goal;
        logic   position_mode;
        t_count detent_counter;
        logic   enable;
        t_mode  active_mode;
    } t_state;

    typedef struct packed {
        logic clear_angle;
        logic clear_velocity;
    } t_pulse;

endpackage

// ===== rtl/core/hkmc_apb_regs.sv =====
`timescale 1ns / 1ps

module hkmc_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hkmc_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [hkmc_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [hkmc_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                                pready,
    output hkmc_pkg::t_cfg                      o_cfg
);

    hkmc_pkg::t_cfg                      r_cfg;
    logic [hkmc_pkg::IDX_WIDTH-1:0]      w_idx;
    logic                                w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[hkmc_pkg::ADDR_WIDTH-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.knob_mode   <= hkmc_pkg::KNOB_OFF;
            r_cfg.zero_offset <= '0;
            r_cfg.detent_step <= hkmc_pkg::DETENT_STEP_RST;
            r_cfg.limit_high  <= hkmc_pkg::LIMIT_HIGH_RST;
            r_cfg.limit_low   <= hkmc_pkg::LIMIT_LOW_RST;
        end else if (w_wr) begin
            case (w_idx)
                hkmc_pkg::REG_KNOB_MODE:   r_cfg.knob_mode   <= pwdata[hkmc_pkg::MODE_WIDTH-1:0];
                hkmc_pkg::REG_ZERO_OFFSET: r_cfg.zero_offset <= pwdata[hkmc_pkg::ANGLE_WIDTH-1:0];
                hkmc_pkg::REG_DETENT_STEP: r_cfg.detent_step <= pwdata[hkmc_pkg::STEP_WIDTH-1:0];
                hkmc_pkg::REG_LIMIT_HIGH:  r_cfg.limit_high  <= pwdata[hkmc_pkg::ANGLE_WIDTH-1:0];
                hkmc_pkg::REG_LIMIT_LOW:   r_cfg.limit_low   <= pwdata[hkmc_pkg::ANGLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            hkmc_pkg::REG_KNOB_MODE:   prdata = hkmc_pkg::DATA_WIDTH'(r_cfg.knob_mode);
            hkmc_pkg::REG_ZERO_OFFSET: prdata = hkmc_pkg::DATA_WIDTH'(r_cfg.zero_offset);
            hkmc_pkg::REG_DETENT_STEP: prdata = hkmc_pkg::DATA_WIDTH'(r_cfg.detent_step);
            hkmc_pkg::REG_LIMIT_HIGH:  prdata = hkmc_pkg::DATA_WIDTH'(r_cfg.limit_high);
            hkmc_pkg::REG_LIMIT_LOW:   prdata = hkmc_pkg::DATA_WIDTH'(r_cfg.limit_low);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/hkmc_mode_logic.sv =====
`timescale 1ns / 1ps

module hkmc_mode_logic (
    input  hkmc_pkg::t_op      i_op,
    input  hkmc_pkg::t_angle   i_angle,
    input  hkmc_pkg::t_angle   i_velocity,
    input  hkmc_pkg::t_cfg     i_cfg,
    input  hkmc_pkg::t_state   i_state,
    output hkmc_pkg::t_state   o_state,
    output hkmc_pkg::t_pulse   o_pulse
);

    hkmc_pkg::t_calc w_ang;
    hkmc_pkg::t_calc w_vel;
    hkmc_pkg::t_calc w_rel;
    hkmc_pkg::t_calc w_d_ang;
    hkmc_pkg::t_calc w_d_vel;
    hkmc_pkg::t_calc w_half;
    hkmc_pkg::t_calc w_hi;
    hkmc_pkg::t_calc w_lo;
    logic            w_up;
    logic            w_dn;

    assign w_ang   = hkmc_pkg::t_calc'($signed(i_angle));
    assign w_vel   = hkmc_pkg::t_calc'($signed(i_velocity));
    assign w_rel   = w_ang - hkmc_pkg::t_calc'($signed(i_cfg.zero_offset));
    assign w_d_ang = w_rel - hkmc_pkg::t_calc'($signed(i_state.last_angle));
    assign w_d_vel = w_vel - hkmc_pkg::t_calc'($signed(i_state.last_velocity));
    assign w_half  = hkmc_pkg::t_calc'({1'b0, i_cfg.detent_step[hkmc_pkg::STEP_WIDTH-1:1]});
    assign w_hi    = hkmc_pkg::t_calc'($signed(i_cfg.limit_high));
    assign w_lo    = hkmc_pkg::t_calc'($signed(i_cfg.limit_low));
    assign w_up    = w_d_ang > w_half;
    assign w_dn    = w_d_ang < -w_half;

    always_comb begin
        o_state = i_state;
        o_pulse = '0;
        if (i_op == hkmc_pkg::OP_START) begin
            o_state.last_angle    = i_angle;
            o_state.last_velocity = i_velocity;
            o_pulse.clear_angle    = 1'b1;
            o_pulse.clear_velocity = 1'b1;
            case (i_cfg.knob_mode)
                hkmc_pkg::KNOB_OFF: begin
                    o_state.enable      = 1'b0;
                    o_state.active_mode = hkmc_pkg::KNOB_OFF;
                end
                hkmc_pkg::KNOB_INERTIA, hkmc_pkg::KNOB_DAMPER: begin
                    o_state.position_mode = 1'b0;
                    o_state.velocity_goal = '0;
                    o_state.active_mode   = hkmc_pkg::t_mode'(i_cfg.knob_mode);
                    o_state.enable        = 1'b1;
                end
                hkmc_pkg::KNOB_DETENT, hkmc_pkg::KNOB_SPRING: begin
                    o_state.position_mode = 1'b1;
                    o_state.angle_goal    = hkmc_pkg::START_ANGLE;
                    if (i_cfg.knob_mode == hkmc_pkg::KNOB_DETENT) begin
                        o_state.last_angle = hkmc_pkg::START_ANGLE;
                    end
                    o_state.active_mode   = hkmc_pkg::t_mode'(i_cfg.knob_mode);
                    o_state.enable        = 1'b1;
                end
                hkmc_pkg::KNOB_SPIN: begin
                    o_state.position_mode = 1'b0;
                    o_state.velocity_goal = hkmc_pkg::SPIN_VELOCITY;
                    o_state.active_mode   = hkmc_pkg::KNOB_SPIN;
                    o_state.enable        = 1'b1;
                end
                default: ;
            endcase
        end else begin
            case (i_state.active_mode)
                hkmc_pkg::KNOB_INERTIA: begin
                    if (w_vel > hkmc_pkg::ONE_Q || w_vel < -hkmc_pkg::ONE_Q) begin
                        if (w_d_vel > hkmc_pkg::THREE_Q || w_d_vel < -hkmc_pkg::THREE_Q) begin
                            o_state.velocity_goal = i_velocity;
                        end
                    end else begin
                        o_state.velocity_goal = '0;
                    end
                    o_state.last_velocity = i_velocity;
                end
                hkmc_pkg::KNOB_DETENT: begin
                    if (w_up || w_dn) begin
                        if (w_up) begin
                            o_state.angle_goal     = i_state.angle_goal
                                + hkmc_pkg::ANGLE_WIDTH'(i_cfg.detent_step);
                            o_state.detent_counter = i_state.detent_counter
                                + hkmc_pkg::COUNT_WIDTH'(1);
                        end else begin
                            o_state.angle_goal     = i_state.angle_goal
                                - hkmc_pkg::ANGLE_WIDTH'(i_cfg.detent_step);
                            o_state.detent_counter = i_state.detent_counter
                                - hkmc_pkg::COUNT_WIDTH'(1);
                        end
                        o_state.last_angle  = o_state.angle_goal;
                        o_pulse.clear_angle = 1'b1;
                    end
                end
                hkmc_pkg::KNOB_DAMPER: begin
                    if (i_cfg.limit_high != '0 && i_cfg.limit_low != '0) begin
                        if (w_rel > w_hi) begin
                            o_state.position_mode = 1'b1;
                            o_state.angle_goal    = i_cfg.limit_high;
                            o_pulse.clear_angle   = 1'b1;
                        end else if (w_rel < w_lo) begin
                            o_state.position_mode = 1'b1;
                            o_state.angle_goal    = i_cfg.limit_low;
                            o_pulse.clear_angle   = 1'b1;
                        end else begin
                            o_state.position_mode  = 1'b0;
                            o_state.velocity_goal  = '0;
                            o_pulse.clear_velocity = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/haptic_knob_mode_controller.sv =====
`timescale 1ns / 1ps
// Knob mode controller: turns measured shaft angle and velocity into loop targets.
// Input stream (s_axis): one beat per control tick or start command; tuser carries
//   the operation (0 tick, 1 start the mode held in the knob_mode register).
// Output stream (m_axis): one result beat per input beat, in order.
// Configuration: APB registers knob_mode, zero_offset, detent_step, limit_high and
//   limit_low at byte addresses 0, 4, 8, 12 and 16; write only while the block is idle.
// Throughput: one beat per cycle while m_axis_tready is high; each beat is worked out by one pass of compare and
//   add logic between the input register and the result register.
// Path: an accepted beat waits in the input register and is loaded into the result
//   register once that register is empty or being taken, and is then offered on m_axis.
// Stall: when m_axis_tready is low the result holds and one further beat waits in the
//   input register; s_axis_tready drops only when both registers are full.
// Reset: synchronous, active low; clears both stages, all targets, the detent count
//   and the active mode (disabled, motor off); registers return to their defaults.

`include "assert_macros.svh"

module haptic_knob_mode_controller (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [hkmc_pkg::ADDR_WIDTH-1:0]         paddr,
    input  logic [hkmc_pkg::DATA_WIDTH-1:0]         pwdata,
    output logic [hkmc_pkg::DATA_WIDTH-1:0]         prdata,
    output logic                                    pready,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // measured_angle, measured_velocity
    input  logic [hkmc_pkg::IN_DATA_WIDTH-1:0]      i_s_axis_tdata,
    // operation
    input  logic                                    i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // target_angle, target_velocity, position_loop, clear_angle_pid,
    // clear_velocity_pid, detent_count, motor_enable, zero fill
    output logic [hkmc_pkg::OUT_DATA_WIDTH-1:0]     o_m_axis_tdata
);

    localparam int AW = hkmc_pkg::ANGLE_WIDTH;

    hkmc_pkg::t_cfg                         w_cfg;
    hkmc_pkg::t_state                       r_state;
    hkmc_pkg::t_state                       n_state;
    hkmc_pkg::t_pulse                       n_pulse;

    logic                                   r_s1_valid;
    hkmc_pkg::t_op                          r_s1_op;
    hkmc_pkg::t_angle                       r_s1_angle;
    hkmc_pkg::t_angle                       r_s1_velocity;

    logic                                   r_out_valid;
    logic [hkmc_pkg::OUT_DATA_WIDTH-1:0]    r_out_data;
    logic [hkmc_pkg::OUT_DATA_WIDTH-1:0]    n_out_data;

    logic                                   w_advance;
    logic                                   w_take;

    hkmc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hkmc_mode_logic u_mode (
        .i_op       (r_s1_op),
        .i_angle    (r_s1_angle),
        .i_velocity (r_s1_velocity),
        .i_cfg      (w_cfg),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_pulse    (n_pulse)
    );

    assign w_advance       = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || w_advance;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign n_out_data = hkmc_pkg::OUT_DATA_WIDTH'({
        n_state.enable,
        n_state.detent_counter,
        n_pulse.clear_velocity,
        n_pulse.clear_angle,
        n_state.position_mode,
        n_state.velocity_goal,
        n_state.angle_goal
    });

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_op       <= hkmc_pkg::t_op'(i_s_axis_tuser);
            r_s1_angle    <= i_s_axis_tdata[AW-1:0];
            r_s1_velocity <= i_s_axis_tdata[2*AW-1:AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    `ASSERT_NOW(a_enable_matches_mode, 1'b1,
        r_state.enable == (r_state.active_mode != hkmc_pkg::KNOB_OFF))
    `ASSERT_NOW(a_ready_when_out_empty, !r_out_valid, o_s_axis_tready)
    `ASSERT_NEXT(a_start_clears_both, w_advance && r_s1_op == hkmc_pkg::OP_START,
        r_out_valid && r_out_data[2*AW+1] && r_out_data[2*AW+2])

endmodule

// ===== sim/haptic_knob_mode_controller_tb.sv =====
`timescale 1ns / 1ps

module haptic_knob_mode_controller_tb;
    import hkmc_pkg::*;

    localparam int ONE         = 1 << FRACTION_BITS;
    localparam int ANGLE_MAX   = (1 << (ANGLE_WIDTH - 1)) - 1;
    localparam int ANGLE_MIN   = -(1 << (ANGLE_WIDTH - 1));
    localparam int STEP_MAX    = 411775;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS = 380;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [OUT_DATA_WIDTH-OUT_FIELDS-1:0] zero_fill;
        logic                                 motor_enable;
        t_count                               detent_count;
        logic                                 clear_velocity_pid;
        logic                                 clear_angle_pid;
        logic                                 position_loop;
        t_angle                               target_velocity;
        t_angle                               target_angle;
    } t_knob_targets;

    class mode_target_tracker;
        logic [MODE_WIDTH-1:0] knob_mode;
        t_angle                zero_offset;
        t_step                 detent_step;
        t_angle                limit_high;
        t_angle                limit_low;
        t_angle                last_angle;
        t_angle                last_velocity;
        t_angle                angle_goal;
        t_angle                velocity_goal;
        logic                  position_mode;
        logic                  enable;
        t_count                detent_counter;
        t_mode                 active_mode;
        t_knob_targets         due_targets[$];
        int                    mismatches;

        function new();
            knob_mode      = KNOB_OFF;
            zero_offset    = '0;
            detent_step    = DETENT_STEP_RST;
            limit_high     = LIMIT_HIGH_RST;
            limit_low      = LIMIT_LOW_RST;
            last_angle     = '0;
            last_velocity  = '0;
            angle_goal     = '0;
            velocity_goal  = '0;
            position_mode  = 1'b0;
            enable         = 1'b0;
            detent_counter = '0;
            active_mode    = KNOB_OFF;
            mismatches     = 0;
        endfunction

        function void set_register(logic [IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] value);
            case (idx)
                REG_KNOB_MODE:   knob_mode   = value[MODE_WIDTH-1:0];
                REG_ZERO_OFFSET: zero_offset = value[ANGLE_WIDTH-1:0];
                REG_DETENT_STEP: detent_step = value[STEP_WIDTH-1:0];
                REG_LIMIT_HIGH:  limit_high  = value[ANGLE_WIDTH-1:0];
                REG_LIMIT_LOW:   limit_low   = value[ANGLE_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function void take_beat(t_op op, t_angle angle, t_angle velocity);
            longint        one, vel, rel, d, half, g, hi, lo;
            logic          clr_a, clr_v;
            t_knob_targets exp;
            one   = longint'(ONE_VAL);
            vel   = $signed(velocity);
            rel   = $signed(angle);
            rel   = rel - $signed(zero_offset);
            clr_a = 1'b0;
            clr_v = 1'b0;
            if (op == OP_START) begin
                last_angle    = angle;
                last_velocity = velocity;
                clr_a         = 1'b1;
                clr_v         = 1'b1;
                case (knob_mode)
                    KNOB_OFF: begin
                        enable      = 1'b0;
                        active_mode = KNOB_OFF;
                    end
                    KNOB_INERTIA, KNOB_DAMPER: begin
                        position_mode = 1'b0;
                        velocity_goal = '0;
                        active_mode   = t_mode'(knob_mode);
                        enable        = 1'b1;
                    end
                    KNOB_DETENT, KNOB_SPRING: begin
                        position_mode = 1'b1;
                        angle_goal    = START_ANGLE;
                        if (knob_mode == KNOB_DETENT) last_angle = START_ANGLE;
                        active_mode   = t_mode'(knob_mode);
                        enable        = 1'b1;
                    end
                    KNOB_SPIN: begin
                        position_mode = 1'b0;
                        velocity_goal = SPIN_VELOCITY;
                        active_mode   = KNOB_SPIN;
                        enable        = 1'b1;
                    end
                    default: ;
                endcase
            end else begin
                case (active_mode)
                    KNOB_INERTIA: begin
                        if (vel > one || vel < -one) begin
                            d = vel - $signed(last_velocity);
                            if (d > 3 * one || d < -3 * one) velocity_goal = velocity;
                        end else begin
                            velocity_goal = '0;
                        end
                        last_velocity = velocity;
                    end
                    KNOB_DETENT: begin
                        d    = rel - $signed(last_angle);
                        half = detent_step >> 1;
                        if (d > half || d < -half) begin
                            g = $signed(angle_goal);
                            if (d > half) begin
                                angle_goal     = t_angle'(g + detent_step);
                                detent_counter = detent_counter + 1'b1;
                            end else begin
                                angle_goal     = t_angle'(g - detent_step);
                                detent_counter = detent_counter - 1'b1;
                            end
                            last_angle = angle_goal;
                            clr_a      = 1'b1;
                        end
                    end
                    KNOB_DAMPER: begin
                        if (limit_high != '0 && limit_low != '0) begin
                            hi = $signed(limit_high);
                            lo = $signed(limit_low);
                            if (rel > hi) begin
                                position_mode = 1'b1;
                                angle_goal    = limit_high;
                                clr_a         = 1'b1;
                            end else if (rel < lo) begin
                                position_mode = 1'b1;
                                angle_goal    = limit_low;
                                clr_a         = 1'b1;
                            end else begin
                                position_mode = 1'b0;
                                velocity_goal = '0;
                                clr_v         = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            exp                    = '0;
            exp.target_angle       = angle_goal;
            exp.target_velocity    = velocity_goal;
            exp.position_loop      = position_mode;
            exp.clear_angle_pid    = clr_a;
            exp.clear_velocity_pid = clr_v;
            exp.detent_count       = detent_counter;
            exp.motor_enable       = enable;
            due_targets.push_back(exp);
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_beat(t_knob_targets got);
            t_knob_targets exp;
            if (due_targets.size() == 0) begin
                $error("result beat with no result pending: 0x%0h", got);
                mismatches++;
                return;
            end
            exp = due_targets.pop_front();
            check_field("target_angle", exp.target_angle, got.target_angle);
            check_field("target_velocity", exp.target_velocity, got.target_velocity);
            check_field("position_loop", exp.position_loop, got.position_loop);
            check_field("clear_angle_pid", exp.clear_angle_pid, got.clear_angle_pid);
            check_field("clear_velocity_pid", exp.clear_velocity_pid, got.clear_velocity_pid);
            check_field("detent_count", exp.detent_count, got.detent_count);
            check_field("motor_enable", exp.motor_enable, got.motor_enable);
            check_field("zero_fill", exp.zero_fill, got.zero_fill);
        endfunction
    endclass

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [ADDR_WIDTH-1:0]     paddr           = '0;
    logic [DATA_WIDTH-1:0]     pwdata          = '0;
    logic [DATA_WIDTH-1:0]     prdata;
    logic                      pready;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]  i_s_axis_tdata  = '0;
    logic                      i_s_axis_tuser  = OP_TICK;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] o_m_axis_tdata;

    mode_target_tracker tracker;
    int                 idle_pct     = 0;
    int                 stall_pct    = 0;
    logic               hold_request = 1'b0;
    int                 items_sent   = 0;
    int                 cycle_count  = 0;

    haptic_knob_mode_controller i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) tracker.check_beat(o_m_axis_tdata);
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                tracker.take_beat(t_op'(i_s_axis_tuser), i_s_axis_tdata[ANGLE_WIDTH-1:0],
                                  i_s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]);
            end
        end
    end

    initial begin
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_beat(input t_op op, input int angle, input int velocity);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {t_angle'(velocity), t_angle'(angle)};
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.due_targets.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [IDX_WIDTH-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_register(idx, value);
        @(posedge i_clk);
    endtask

    function automatic int pick_angle();
        case ($urandom_range(7))
            0:       return ANGLE_MAX;
            1:       return ANGLE_MIN;
            2:       return 0;
            3, 4:    return int'($urandom_range(16 * ONE)) - 8 * ONE;
            default: return $signed(t_angle'($urandom));
        endcase
    endfunction

    task automatic run_segment(input int count, input bit squeeze);
        int mode, zo, step, hi, lo, track, rate, vel, reach;
        mode = ($urandom_range(19) == 0) ? $urandom_range(2**MODE_WIDTH - 1, KNOB_SPIN + 1)
                                         : $urandom_range(KNOB_SPIN);
        zo   = pick_angle();
        hi   = pick_angle();
        lo   = pick_angle();
        case ($urandom_range(5))
            0:       step = 0;
            1:       step = STEP_MAX;
            2:       step = DETENT_STEP_RST;
            default: step = $urandom_range(STEP_MAX, 1);
        endcase
        wait_idle();
        write_register(REG_KNOB_MODE, mode);
        write_register(REG_ZERO_OFFSET, zo);
        write_register(REG_DETENT_STEP, step);
        write_register(REG_LIMIT_HIGH, hi);
        write_register(REG_LIMIT_LOW, lo);
        send_beat(OP_START, int'($urandom), int'($urandom));
        if (squeeze) hold_request <= 1'b1;
        reach = step + ONE / 4;
        rate  = int'($urandom_range(2 * reach)) - reach;
        track = START_ANGLE;
        vel   = 0;
        if (mode == KNOB_DETENT && $urandom_range(1)) rate = $urandom_range(1) ? step + 1
                                                                               : -step - 1;
        if (mode == KNOB_DAMPER) begin
            track = ((lo < hi) ? lo : hi) - 2 * ONE;
            rate  = (((hi > lo) ? hi - lo : lo - hi) + 4 * ONE) / count;
        end
        repeat (count) begin
            case ($urandom_range(24))
                0:       send_beat(OP_START, int'($urandom), int'($urandom));
                1, 2:    send_beat(OP_TICK, int'($urandom), int'($urandom));
                default: begin
                    track += rate + int'($urandom_range(ONE / 4)) - ONE / 8;
                    case ($urandom_range(4))
                        0: vel = int'($urandom_range(4 * ONE)) - 2 * ONE;
                        1: vel = vel + ($urandom_range(1) ? 3 * ONE : -3 * ONE)
                                 + int'($urandom_range(2)) - 1;
                        2: vel = int'($urandom_range(32 * ONE)) - 16 * ONE;
                        default: vel = vel + int'($urandom_range(ONE / 2)) - ONE / 4;
                    endcase
                    send_beat(OP_TICK, track + zo, vel);
                end
            endcase
        end
    endtask

    initial begin
        int phase_idle[4];
        int phase_stall[4];
        int quota;
        phase_idle  = '{0, 81, 0, 18};
        phase_stall = '{0, 0, 81, 18};
        tracker     = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(OP_TICK, ANGLE_MAX, ANGLE_MIN);
        send_beat(OP_START, ANGLE_MIN, ANGLE_MAX);

        wait_idle();
        write_register(REG_KNOB_MODE, KNOB_INERTIA);
        send_beat(OP_START, 0, 0);
        send_beat(OP_TICK, 0, ONE);
        send_beat(OP_TICK, 0, ONE + 1);
        send_beat(OP_TICK, 0, 4 * ONE + 2);
        send_beat(OP_TICK, 0, -ONE - 1);
        send_beat(OP_TICK, 0, -ONE);
        send_beat(OP_TICK, 0, ANGLE_MIN);
        send_beat(OP_TICK, 0, ANGLE_MAX);

        wait_idle();
        write_register(REG_KNOB_MODE, KNOB_DETENT);
        send_beat(OP_START, 0, 0);
        send_beat(OP_TICK, int'(START_ANGLE) + int'(DETENT_STEP_RST >> 1), 0);
        send_beat(OP_TICK, int'(START_ANGLE) + int'(DETENT_STEP_RST >> 1) + 1, 0);
        send_beat(OP_TICK, int'(START_ANGLE) + int'(DETENT_STEP_RST)
                           - int'(DETENT_STEP_RST >> 1) - 1, 0);
        send_beat(OP_TICK, ANGLE_MIN, ANGLE_MAX);
        send_beat(OP_TICK, ANGLE_MAX, ANGLE_MIN);

        wait_idle();
        write_register(REG_KNOB_MODE, KNOB_SPRING);
        send_beat(OP_START, ONE, ONE);
        send_beat(OP_TICK, ANGLE_MAX, ANGLE_MAX);

        wait_idle();
        write_register(REG_KNOB_MODE, KNOB_SPIN);
        send_beat(OP_START, ONE, -ONE);
        send_beat(OP_TICK, ANGLE_MIN, ANGLE_MIN);

        wait_idle();
        write_register(REG_KNOB_MODE, KNOB_DAMPER);
        send_beat(OP_START, 0, 0);
        send_beat(OP_TICK, int'(LIMIT_HIGH_RST) + 1, 0);
        send_beat(OP_TICK, int'(LIMIT_LOW_RST) - 1, 0);
        send_beat(OP_TICK, (int'(LIMIT_HIGH_RST) + int'(LIMIT_LOW_RST)) / 2, 0);

        wait_idle();
        write_register(REG_LIMIT_LOW, 0);
        send_beat(OP_TICK, int'(LIMIT_HIGH_RST) + ONE, 0);
        for (int m = KNOB_SPIN + 1; m < 2**MODE_WIDTH; m++) begin
            wait_idle();
            write_register(REG_KNOB_MODE, m);
            send_beat(OP_START, ONE, ONE);
            send_beat(OP_TICK, 0, 0);
        end

        for (int p = 0; p < 4; p++) begin
            idle_pct  <= phase_idle[p];
            stall_pct <= phase_stall[p];
            quota = items_sent + PHASE_ITEMS;
            if (p == 0) run_segment(48, 1'b1);
            while (items_sent < quota) run_segment($urandom_range(48, 10), 1'b0);
        end

        wait_idle();
        if (tracker.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hkmc_pkg.sv
rtl/core/hkmc_apb_regs.sv
rtl/core/hkmc_mode_logic.sv
rtl/core/haptic_knob_mode_controller.sv
sim/haptic_knob_mode_controller_tb.sv
